// File: rtl/hgp_pkg.sv
// ----------------------------------------------------------------------------
// hgp_pkg: shared types and constants of the horizontal glyph placer
// Beat structs, configuration register file type, queue entry and op codes.
// ----------------------------------------------------------------------------
package hgp_pkg;

   // character kind codes carried in the input beat
   localparam logic [2:0] KIND_OTHER      = 3'd0;
   localparam logic [2:0] KIND_SPACE      = 3'd1;
   localparam logic [2:0] KIND_WIDE_SPACE = 3'd2;
   localparam logic [2:0] KIND_TAB        = 3'd3;
   localparam logic [2:0] KIND_NEWLINE    = 3'd4;

   // result kind codes
   localparam logic RESULT_NEW     = 1'b0;
   localparam logic RESULT_REPLACE = 1'b1;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_START_POSITION = 3'd0,
      CSR_SCALE_Q8       = 3'd1,
      CSR_EXTRA_ADVANCE  = 3'd2,
      CSR_SPACE_ADVANCE  = 3'd3,
      CSR_WIDE_ADVANCE   = 3'd4,
      CSR_TAB_ADVANCE    = 3'd5,
      CSR_LINE_PITCH     = 3'd6,
      CSR_MODE_FLAGS     = 3'd7
   } csr_index_type;

   // work the back end performs for one queued beat
   typedef enum logic [1:0] {
      OP_GLYPH   = 2'd0,
      OP_ADVANCE = 2'd1,
      OP_NEWLINE = 2'd2
   } op_type;

   typedef struct packed {
      logic        visible;
      logic [2:0]  char_kind;
      logic [20:0] glyph_code;
      logic [11:0] advance_width;
      logic [11:0] glyph_height;
      logic        forbids_line_end;
      logic        next_visible_exists;
      logic        next_forbids_line_start;
      logic [15:0] style_index;
      logic        last_in_string;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [20:0]        out_glyph_code;
      logic [15:0]        out_style_index;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        start_x;
      logic [15:0]        start_y;
      logic [15:0]        scale_q8;
      logic signed [10:0] extra_advance;
      logic [11:0]        space_advance;
      logic [11:0]        wide_space_advance;
      logic [11:0]        tab_advance;
      logic [11:0]        line_pitch;
      logic               rotate_swap;
      logic               edge_check;
   } cfg_type;

   // classified beat passed from front end to back end
   typedef struct packed {
      op_type      op;
      logic [15:0] advance;
      logic [20:0] glyph_code;
      logic [15:0] style_index;
      logic        forbids_line_end;
      logic        next_visible_exists;
      logic        next_forbids_line_start;
      logic        last_in_string;
   } entry_type;

endpackage

// File: rtl/horizontal_glyph_placer.sv
// ----------------------------------------------------------------------------
// horizontal_glyph_placer: left-to-right pen placement of a character stream
// One request beat per character; a placement beat per visible glyph and per
// newline that rolls the last glyph down to the next line.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : character beats, taken when req_valid is high and req_stall low.
//   rsp_*  : placement beats, taken when rsp_valid is high and rsp_stall low.
//   csr_*  : register writes (index, data); csr_ready is always high. Write
//            only while the block is idle. Writing the start position also
//            moves the pen there.
// Throughput: one character per cycle while the queue has room. The front end
//   scales the advance with a single 14x17 multiply; the back end moves the pen
//   with one add per glyph or advance beat; each placement is registered.
// The front end stalls only when the QUEUE_DEPTH-entry queue is full; the
//   back end keeps consuming non-emitting beats while a placement waits in
//   the output register, and stops only at the next emitting beat.
// Reset: registers return to their defaults (scale 1.0, everything else
//   zero), the pen goes to (0, 0) and the queue empties. No clearing pass.
// After a beat marked last in string, pen and line state return to the start.
// ----------------------------------------------------------------------------
module horizontal_glyph_placer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hgp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hgp_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   hgp_pkg::cfg_type   cfg_ff, cfg_in;
   hgp_pkg::entry_type push_entry;
   hgp_pkg::entry_type head_entry;
   logic               csr_write;
   logic               start_load;
   logic               push;
   logic               pop;
   logic               queue_full;
   logic               head_valid;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign start_load = csr_write
                     && (hgp_pkg::csr_index_type'(csr_index) == hgp_pkg::CSR_START_POSITION);

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (hgp_pkg::csr_index_type'(csr_index))
            hgp_pkg::CSR_START_POSITION: begin
               cfg_in.start_x = csr_wdata[15:0];
               cfg_in.start_y = csr_wdata[31:16];
            end
            hgp_pkg::CSR_SCALE_Q8:      cfg_in.scale_q8           = csr_wdata[15:0];
            hgp_pkg::CSR_EXTRA_ADVANCE: cfg_in.extra_advance      = $signed(csr_wdata[10:0]);
            hgp_pkg::CSR_SPACE_ADVANCE: cfg_in.space_advance      = csr_wdata[11:0];
            hgp_pkg::CSR_WIDE_ADVANCE:  cfg_in.wide_space_advance = csr_wdata[11:0];
            hgp_pkg::CSR_TAB_ADVANCE:   cfg_in.tab_advance        = csr_wdata[11:0];
            hgp_pkg::CSR_LINE_PITCH:    cfg_in.line_pitch         = csr_wdata[11:0];
            hgp_pkg::CSR_MODE_FLAGS: begin
               cfg_in.rotate_swap = csr_wdata[0];
               cfg_in.edge_check  = csr_wdata[1];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x            <= '0;
         cfg_ff.start_y            <= '0;
         cfg_ff.scale_q8           <= 16'd256;
         cfg_ff.extra_advance      <= '0;
         cfg_ff.space_advance      <= '0;
         cfg_ff.wide_space_advance <= '0;
         cfg_ff.tab_advance        <= '0;
         cfg_ff.line_pitch         <= '0;
         cfg_ff.rotate_swap        <= 1'b0;
         cfg_ff.edge_check         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hgp_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   hgp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   hgp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start_load  (start_load),
      .start_value (csr_wdata),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// File: rtl/hgp_front.sv
// ----------------------------------------------------------------------------
// hgp_front: input classification and advance scaling
// Accepts request beats, decodes the character kind and computes the scaled
// pen advance, then pushes one entry per beat into the queue.
// ----------------------------------------------------------------------------
module hgp_front (
   input  logic                req_valid,
   output logic                req_stall,
   input  hgp_pkg::req_type    req_data,
   input  hgp_pkg::cfg_type    cfg,
   input  logic                queue_full,
   output logic                push,
   output hgp_pkg::entry_type  entry
);

   logic [11:0]        width_sel;
   logic signed [13:0] width_sum;
   logic signed [29:0] product;
   logic signed [29:0] biased;
   logic [15:0]        glyph_adv;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // scaled advance: trunc toward zero of (w + extra) * scale / 256
   always_comb begin
      width_sel = (req_data.visible && cfg.rotate_swap) ? req_data.glyph_height
                                                       : req_data.advance_width;
      width_sum = $signed({2'b00, width_sel})
                + $signed({{3{cfg.extra_advance[10]}}, cfg.extra_advance});
      product   = width_sum * $signed({1'b0, cfg.scale_q8});
      biased    = product + (product[29] ? 30'sd255 : 30'sd0);
      glyph_adv = biased[23:8];
   end

   // classify the beat
   always_comb begin
      entry.advance                 = glyph_adv;
      entry.glyph_code              = req_data.glyph_code;
      entry.style_index             = req_data.style_index;
      entry.forbids_line_end        = req_data.forbids_line_end;
      entry.next_visible_exists     = req_data.next_visible_exists;
      entry.next_forbids_line_start = req_data.next_forbids_line_start;
      entry.last_in_string          = req_data.last_in_string;
      entry.op                      = hgp_pkg::OP_ADVANCE;
      if (req_data.visible) begin
         entry.op = hgp_pkg::OP_GLYPH;
      end else begin
         case (req_data.char_kind)
            hgp_pkg::KIND_SPACE: begin
               entry.advance = {4'd0, cfg.space_advance};
            end
            hgp_pkg::KIND_WIDE_SPACE: begin
               entry.advance = {4'd0, cfg.wide_space_advance};
            end
            hgp_pkg::KIND_TAB: begin
               entry.advance = {4'd0, cfg.tab_advance};
            end
            hgp_pkg::KIND_NEWLINE: begin
               entry.op = hgp_pkg::OP_NEWLINE;
            end
            default: begin
               // other invisible characters advance like an unrotated glyph
               entry.op = hgp_pkg::OP_ADVANCE;
            end
         endcase
      end
   end

endmodule

// File: rtl/hgp_queue.sv
// ----------------------------------------------------------------------------
// hgp_queue: short FIFO between front and back end
// Register-based queue of classified beats; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module hgp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hgp_pkg::entry_type  push_entry,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output hgp_pkg::entry_type  head_entry
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   hgp_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue push while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("queue pop while empty");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

endmodule

// File: rtl/hgp_back.sv
// ----------------------------------------------------------------------------
// hgp_back: pen state and result register
// Pops classified beats, applies pen moves and line-break rules, and holds
// each placement in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module hgp_back (
   input  logic                clock,
   input  logic                reset,
   input  hgp_pkg::cfg_type    cfg,
   input  logic                start_load,
   input  logic [31:0]         start_value,
   input  logic                head_valid,
   input  hgp_pkg::entry_type  head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hgp_pkg::rsp_type    rsp_data
);

   logic [15:0] pen_x_ff, pen_x_in;
   logic [15:0] pen_y_ff, pen_y_in;
   logic        prev_forbids_ff, prev_forbids_in;
   logic [15:0] prev_adv_ff, prev_adv_in;
   logic [20:0] prev_glyph_ff, prev_glyph_in;
   logic [15:0] prev_style_ff, prev_style_in;
   logic        any_visible_ff, any_visible_in;
   logic        para_start_ff, para_start_in;
   logic        rsp_valid_ff, rsp_valid_in;
   hgp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        rollback;
   logic        keep;
   logic        emits;
   logic        out_free;
   logic [15:0] next_line_y;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // line-edge decision for a newline beat, and when the head beat may pop
   always_comb begin
      rollback    = cfg.edge_check && prev_forbids_ff && any_visible_ff
                  && head_entry.next_visible_exists;
      keep        = cfg.edge_check && !para_start_ff && head_entry.next_visible_exists
                  && head_entry.next_forbids_line_start;
      emits       = (head_entry.op == hgp_pkg::OP_GLYPH)
                  || ((head_entry.op == hgp_pkg::OP_NEWLINE) && rollback && !keep);
      out_free    = !rsp_valid_ff || !rsp_stall;
      pop         = head_valid && (!emits || out_free);
      next_line_y = pen_y_ff + {4'd0, cfg.line_pitch};
   end

   // pen state and result update
   always_comb begin
      pen_x_in        = pen_x_ff;
      pen_y_in        = pen_y_ff;
      prev_forbids_in = prev_forbids_ff;
      prev_adv_in     = prev_adv_ff;
      prev_glyph_in   = prev_glyph_ff;
      prev_style_in   = prev_style_ff;
      any_visible_in  = any_visible_ff;
      para_start_in   = para_start_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      if (pop) begin
         case (head_entry.op)
            hgp_pkg::OP_GLYPH: begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.result_kind     = hgp_pkg::RESULT_NEW;
               rsp_data_in.pos_x           = $signed(pen_x_ff);
               rsp_data_in.pos_y           = $signed(pen_y_ff);
               rsp_data_in.out_glyph_code  = head_entry.glyph_code;
               rsp_data_in.out_style_index = head_entry.style_index;
               prev_forbids_in = head_entry.forbids_line_end;
               prev_adv_in     = head_entry.advance;
               prev_glyph_in   = head_entry.glyph_code;
               prev_style_in   = head_entry.style_index;
               pen_x_in        = pen_x_ff + head_entry.advance;
               any_visible_in  = 1'b1;
               para_start_in   = 1'b0;
            end
            hgp_pkg::OP_NEWLINE: begin
               if (rollback && !keep) begin
                  // move the last glyph down to the new line
                  rsp_valid_in                = 1'b1;
                  rsp_data_in.result_kind     = hgp_pkg::RESULT_REPLACE;
                  rsp_data_in.pos_x           = $signed(cfg.start_x);
                  rsp_data_in.pos_y           = $signed(next_line_y);
                  rsp_data_in.out_glyph_code  = prev_glyph_ff;
                  rsp_data_in.out_style_index = prev_style_ff;
                  pen_y_in = next_line_y;
                  pen_x_in = cfg.start_x + prev_adv_ff;
               end else if (!rollback && !keep) begin
                  pen_x_in = cfg.start_x;
                  pen_y_in = next_line_y;
               end
               para_start_in   = 1'b1;
               prev_forbids_in = 1'b0;
            end
            default: begin
               pen_x_in = pen_x_ff + head_entry.advance;
            end
         endcase
         if (head_entry.last_in_string) begin
            pen_x_in        = cfg.start_x;
            pen_y_in        = cfg.start_y;
            prev_forbids_in = 1'b0;
            prev_adv_in     = '0;
            prev_glyph_in   = '0;
            prev_style_in   = '0;
            any_visible_in  = 1'b0;
            para_start_in   = 1'b1;
         end
      end
      // start position write reloads the pen
      if (start_load) begin
         pen_x_in = start_value[15:0];
         pen_y_in = start_value[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff        <= '0;
         pen_y_ff        <= '0;
         prev_forbids_ff <= 1'b0;
         prev_adv_ff     <= '0;
         prev_glyph_ff   <= '0;
         prev_style_ff   <= '0;
         any_visible_ff  <= 1'b0;
         para_start_ff   <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pen_x_ff        <= pen_x_in;
         pen_y_ff        <= pen_y_in;
         prev_forbids_ff <= prev_forbids_in;
         prev_adv_ff     <= prev_adv_in;
         prev_glyph_ff   <= prev_glyph_in;
         prev_style_ff   <= prev_style_in;
         any_visible_ff  <= any_visible_in;
         para_start_ff   <= para_start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_glyph_gives_new: assert property (@(posedge clock) disable iff (reset)
      pop && head_entry.op == hgp_pkg::OP_GLYPH
      |=> rsp_valid_ff && rsp_data_ff.result_kind == hgp_pkg::RESULT_NEW)
      else $error("glyph beat did not produce a new placement");

   a_keep_no_result: assert property (@(posedge clock) disable iff (reset)
      pop && head_entry.op == hgp_pkg::OP_NEWLINE && keep && !rsp_valid_ff
      |=> !rsp_valid_ff) else $error("kept newline produced a result");

   a_string_end_resets: assert property (@(posedge clock) disable iff (reset)
      pop && head_entry.last_in_string && !start_load
      |=> pen_x_ff == $past(cfg.start_x) && para_start_ff && !any_visible_ff)
      else $error("pen state not restored after end of string");

   a_held_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && head_valid && emits |-> !pop)
      else $error("result overwritten while receiver stalls");

endmodule

// File: bench/hgp_placement_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hgp_placement_checker: pen tracking and placement scoreboard
// Watches the character, placement and register channels of the glyph placer,
// keeps its own pen and line state, works out the placement each character
// beat should cause and compares every placement beat against the oldest one.
// ----------------------------------------------------------------------------
module hgp_placement_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  hgp_pkg::req_type       req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  hgp_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  hgp_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata,
   output int                     mismatches,
   output int                     placements_waiting,
   output int                     placements_checked,
   output int                     replacements_checked
);

   // register mirror
   hgp_pkg::cfg_type cfg_q;

   // pen and line state
   logic [15:0] pen_x;
   logic [15:0] pen_y;
   logic        prev_forbids_end;
   logic [15:0] prev_advance;
   logic [20:0] prev_glyph;
   logic [15:0] prev_style;
   logic        any_visible;
   logic        paragraph_start;

   // placements owed by the block, oldest first
   hgp_pkg::rsp_type placements_due[$];

   task automatic restart_string();
      pen_x            = cfg_q.start_x;
      pen_y            = cfg_q.start_y;
      prev_forbids_end = 1'b0;
      prev_advance     = '0;
      prev_glyph       = '0;
      prev_style       = '0;
      any_visible      = 1'b0;
      paragraph_start  = 1'b1;
   endtask

   // (w + extra) * scale / 256, truncated toward zero, kept to 16 bits
   function automatic logic [15:0] scaled_advance(input logic [11:0] w);
      int     w_i;
      int     extra_i;
      int     scale_i;
      longint p;
      longint m;
      w_i     = int'(w);
      extra_i = {{21{cfg_q.extra_advance[10]}}, cfg_q.extra_advance};
      scale_i = int'(cfg_q.scale_q8);
      p = longint'(w_i + extra_i) * longint'(scale_i);
      m = (p < 0) ? -p : p;
      m = m >> 8;
      if (p < 0)
         m = -m;
      return m[15:0];
   endfunction

   task automatic apply_csr(input hgp_pkg::csr_index_type idx, input logic [31:0] data);
      case (idx)
         hgp_pkg::CSR_START_POSITION: begin
            cfg_q.start_x = data[15:0];
            cfg_q.start_y = data[31:16];
            pen_x = data[15:0];
            pen_y = data[31:16];
         end
         hgp_pkg::CSR_SCALE_Q8:      cfg_q.scale_q8           = data[15:0];
         hgp_pkg::CSR_EXTRA_ADVANCE: cfg_q.extra_advance      = data[10:0];
         hgp_pkg::CSR_SPACE_ADVANCE: cfg_q.space_advance      = data[11:0];
         hgp_pkg::CSR_WIDE_ADVANCE:  cfg_q.wide_space_advance = data[11:0];
         hgp_pkg::CSR_TAB_ADVANCE:   cfg_q.tab_advance        = data[11:0];
         hgp_pkg::CSR_LINE_PITCH:    cfg_q.line_pitch         = data[11:0];
         hgp_pkg::CSR_MODE_FLAGS: begin
            cfg_q.rotate_swap = data[0];
            cfg_q.edge_check  = data[1];
         end
         default: ;
      endcase
   endtask

   // advance the pen for one character and queue the placement it causes
   task automatic place_char(input hgp_pkg::req_type c);
      hgp_pkg::rsp_type p;
      logic [15:0]      adv;
      logic             rollback;
      logic             keep;
      p = '0;
      if (c.visible) begin
         adv = scaled_advance(cfg_q.rotate_swap ? c.glyph_height : c.advance_width);
         p.result_kind     = hgp_pkg::RESULT_NEW;
         p.pos_x           = pen_x;
         p.pos_y           = pen_y;
         p.out_glyph_code  = c.glyph_code;
         p.out_style_index = c.style_index;
         placements_due    = {placements_due, p};
         prev_forbids_end = c.forbids_line_end;
         prev_advance     = adv;
         prev_glyph       = c.glyph_code;
         prev_style       = c.style_index;
         pen_x            = pen_x + adv;
         any_visible      = 1'b1;
         paragraph_start  = 1'b0;
      end else begin
         case (c.char_kind)
            hgp_pkg::KIND_SPACE:      pen_x = pen_x + 16'(cfg_q.space_advance);
            hgp_pkg::KIND_WIDE_SPACE: pen_x = pen_x + 16'(cfg_q.wide_space_advance);
            hgp_pkg::KIND_TAB:        pen_x = pen_x + 16'(cfg_q.tab_advance);
            hgp_pkg::KIND_NEWLINE: begin
               rollback = cfg_q.edge_check && prev_forbids_end && any_visible &&
                          c.next_visible_exists;
               keep     = cfg_q.edge_check && !paragraph_start &&
                          c.next_visible_exists && c.next_forbids_line_start;
               if (rollback && !keep) begin
                  // last glyph moves down to the start of the new line
                  pen_y = pen_y + 16'(cfg_q.line_pitch);
                  p.result_kind     = hgp_pkg::RESULT_REPLACE;
                  p.pos_x           = cfg_q.start_x;
                  p.pos_y           = pen_y;
                  p.out_glyph_code  = prev_glyph;
                  p.out_style_index = prev_style;
                  placements_due    = {placements_due, p};
                  pen_x = cfg_q.start_x + prev_advance;
               end else if (!rollback && !keep) begin
                  pen_x = cfg_q.start_x;
                  pen_y = pen_y + 16'(cfg_q.line_pitch);
               end
               paragraph_start  = 1'b1;
               prev_forbids_end = 1'b0;
            end
            // other invisible characters and unused kinds move like a glyph
            default: pen_x = pen_x + scaled_advance(c.advance_width);
         endcase
      end
      if (c.last_in_string)
         restart_string();
   endtask

   task automatic flag(input string what, input logic [31:0] exp, input logic [31:0] got);
      $display("%0t checker: %s mismatch, expected %h, got %h", $time, what, exp, got);
      mismatches++;
   endtask

   // placement beat against the oldest owed placement
   task automatic check_placement(input hgp_pkg::rsp_type got);
      hgp_pkg::rsp_type exp;
      if (placements_due.size() == 0) begin
         $display("%0t checker: unexpected placement beat %h", $time, got);
         mismatches++;
      end else begin
         exp = placements_due.pop_front();
         if (got.result_kind !== exp.result_kind)
            flag("result_kind", 32'(exp.result_kind), 32'(got.result_kind));
         if (got.pos_x !== exp.pos_x)
            flag("pos_x", 32'(exp.pos_x), 32'(got.pos_x));
         if (got.pos_y !== exp.pos_y)
            flag("pos_y", 32'(exp.pos_y), 32'(got.pos_y));
         if (got.out_glyph_code !== exp.out_glyph_code)
            flag("out_glyph_code", 32'(exp.out_glyph_code), 32'(got.out_glyph_code));
         if (got.out_style_index !== exp.out_style_index)
            flag("out_style_index", 32'(exp.out_style_index), 32'(got.out_style_index));
         placements_checked++;
         if (exp.result_kind == hgp_pkg::RESULT_REPLACE)
            replacements_checked++;
      end
   endtask

   // sample all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         cfg_q          = '0;
         cfg_q.scale_q8 = 16'd256;
         restart_string();
         placements_due.delete();
         mismatches           = 0;
         placements_checked   = 0;
         replacements_checked = 0;
      end else begin
         if (csr_valid && csr_ready)
            apply_csr(csr_index, csr_wdata);
         if (rsp_valid && !rsp_stall)
            check_placement(rsp_data);
         if (req_valid && !req_stall)
            place_char(req_data);
      end
      placements_waiting = placements_due.size();
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: glyph placer testbench
// Drives short directed strings, then random character strings with mostly valid
// lookahead fields under several register settings and pacing mixes; the
// placement checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [2:0] KIND_UNUSED_5 = 3'd5;
   localparam logic [2:0] KIND_UNUSED_7 = 3'd7;
   localparam int         EPOCHS        = 8;
   localparam int         EPOCH_CHARS   = 228;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   hgp_pkg::req_type       req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   hgp_pkg::rsp_type       rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   hgp_pkg::csr_index_type csr_index;
   logic [31:0]            csr_wdata;

   int mismatches;
   int placements_waiting;
   int placements_checked;
   int replacements_checked;

   int idle_pct;
   int stall_pct;
   int chars_sent;
   int settings_used;

   horizontal_glyph_placer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hgp_placement_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data             (req_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_data             (rsp_data),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatches           (mismatches),
      .placements_waiting   (placements_waiting),
      .placements_checked   (placements_checked),
      .replacements_checked (replacements_checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(12_000_000);
      $display("tb: done, errors");
      $finish;
   end

   // placement side back-pressure
   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   function automatic hgp_pkg::req_type mk(input logic vis, input logic [2:0] kind,
                                           input logic [20:0] code, input logic [11:0] w,
                                           input logic [11:0] h, input logic fe,
                                           input logic nx, input logic nfs,
                                           input logic [15:0] sty, input logic last);
      hgp_pkg::req_type c;
      c.visible                 = vis;
      c.char_kind               = kind;
      c.glyph_code              = code;
      c.advance_width           = w;
      c.glyph_height            = h;
      c.forbids_line_end        = fe;
      c.next_visible_exists     = nx;
      c.next_forbids_line_start = nfs;
      c.style_index             = sty;
      c.last_in_string          = last;
      return c;
   endfunction

   // one character beat, with random idle cycles ahead of it
   task automatic send_char(input hgp_pkg::req_type c);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      chars_sent++;
   endtask

   // register write beat; csr_valid stays up for a following write
   task automatic csr_write(input hgp_pkg::csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // drain owed placements, then give non-emitting beats time to retire
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (placements_waiting != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_settings(input logic [31:0] start, input logic [15:0] scale,
                                 input logic [10:0] extra, input logic [11:0] sp,
                                 input logic [11:0] wide, input logic [11:0] tab,
                                 input logic [11:0] step, input logic [1:0] mode);
      wait_idle();
      csr_write(hgp_pkg::CSR_START_POSITION, start);
      csr_write(hgp_pkg::CSR_SCALE_Q8, {16'b0, scale});
      csr_write(hgp_pkg::CSR_EXTRA_ADVANCE, {21'b0, extra});
      csr_write(hgp_pkg::CSR_SPACE_ADVANCE, {20'b0, sp});
      csr_write(hgp_pkg::CSR_WIDE_ADVANCE, {20'b0, wide});
      csr_write(hgp_pkg::CSR_TAB_ADVANCE, {20'b0, tab});
      csr_write(hgp_pkg::CSR_LINE_PITCH, {20'b0, step});
      csr_write(hgp_pkg::CSR_MODE_FLAGS, {30'b0, mode});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [11:0] pick_size();
      return ($urandom_range(0, 15) == 0) ? 12'($urandom_range(0, 4095))
                                          : 12'($urandom_range(0, 48));
   endfunction

   // one character of a well-formed string, lookahead filled in later
   function automatic hgp_pkg::req_type random_char(input logic [15:0] sty);
      hgp_pkg::req_type c;
      int               r;
      r = $urandom_range(0, 99);
      c = mk(1'b0, hgp_pkg::KIND_OTHER, 21'($urandom_range(0, 1114111)), pick_size(),
             pick_size(), ($urandom_range(0, 99) < 35), 1'b0, 1'b0, sty, 1'b0);
      if (r < 45) begin
         c.visible = 1'b1;
         if ($urandom_range(0, 9) == 0)
            c.char_kind = 3'($urandom_range(0, 7));
      end else if (r < 53)
         c.char_kind = hgp_pkg::KIND_SPACE;
      else if (r < 59)
         c.char_kind = hgp_pkg::KIND_WIDE_SPACE;
      else if (r < 65)
         c.char_kind = hgp_pkg::KIND_TAB;
      else if (r < 88)
         c.char_kind = hgp_pkg::KIND_NEWLINE;
      else if (r < 96)
         c.char_kind = hgp_pkg::KIND_OTHER;
      else
         c.char_kind = 3'($urandom_range(KIND_UNUSED_5, KIND_UNUSED_7));
      return c;
   endfunction

   task automatic send_string();
      hgp_pkg::req_type str[16];
      logic             starts_forbidden[16];
      logic [95:0]      bits;
      logic [15:0]      sty;
      logic             nx;
      logic             nfs;
      int               len;
      int               i;
      len = $urandom_range(1, 12);
      sty = 16'($urandom);
      if ($urandom_range(0, 99) < 12) begin
         // noise: every field random, string boundaries anywhere
         for (i = 0; i < len; i++) begin
            bits = {$urandom, $urandom, $urandom};
            str[i] = bits[68:0];
            str[i].glyph_code = 21'($urandom_range(0, 1114111));
         end
      end else begin
         for (i = 0; i < len; i++) begin
            str[i] = random_char(sty);
            starts_forbidden[i] = ($urandom_range(0, 99) < 40);
         end
         str[len - 1].last_in_string = 1'b1;
         // lookahead to the next visible character, filled from the back
         nx  = 1'b0;
         nfs = 1'b0;
         for (i = len - 1; i >= 0; i--) begin
            str[i].next_visible_exists     = nx;
            str[i].next_forbids_line_start = nfs;
            if (str[i].visible) begin
               nx  = 1'b1;
               nfs = starts_forbidden[i];
            end
         end
         // broken lookahead now and then
         if ($urandom_range(0, 99) < 6) begin
            i = $urandom_range(0, len - 1);
            str[i].next_visible_exists     = ~str[i].next_visible_exists;
            str[i].next_forbids_line_start = 1'($urandom_range(0, 1));
         end
      end
      for (i = 0; i < len; i++)
         send_char(str[i]);
   endtask

   task automatic directed_strings();
      // reset settings: glyph extremes, every named kind and an unused one, plain break
      send_char(mk(1'b1, hgp_pkg::KIND_OTHER, 21'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0,
                   16'h0000, 1'b0));
      send_char(mk(1'b1, hgp_pkg::KIND_OTHER, 21'd1114111, 12'd4095, 12'd4095, 1'b1,
                   1'b1, 1'b1, 16'hFFFF, 1'b0));
      send_char(mk(1'b0, hgp_pkg::KIND_SPACE, 21'd32, 12'd7, 12'd0, 1'b0, 1'b1, 1'b0,
                   16'h1234, 1'b0));
      send_char(mk(1'b0, hgp_pkg::KIND_WIDE_SPACE, 21'd12288, 12'd7, 12'd0, 1'b0, 1'b1,
                   1'b0, 16'h1234, 1'b0));
      send_char(mk(1'b0, hgp_pkg::KIND_TAB, 21'd9, 12'd7, 12'd0, 1'b0, 1'b1, 1'b0,
                   16'h1234, 1'b0));
      send_char(mk(1'b0, hgp_pkg::KIND_OTHER, 21'd173, 12'd100, 12'd0, 1'b0, 1'b1, 1'b0,
                   16'h1234, 1'b0));
      send_char(mk(1'b0, KIND_UNUSED_5, 21'd5, 12'd33, 12'd0, 1'b0, 1'b1, 1'b0,
                   16'h1234, 1'b0));
      send_char(mk(1'b1, hgp_pkg::KIND_NEWLINE, 21'd65, 12'd12, 12'd20, 1'b1, 1'b1, 1'b1,
                   16'h1234, 1'b0));
      send_char(mk(1'b0, hgp_pkg::KIND_NEWLINE, 21'd10, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0,
                   16'h1234, 1'b1));

      // line-edge checks on, negative extra truncates toward zero
      write_settings(32'h0010_0008, 16'd384, 11'h7FD, 12'd5, 12'd10, 12'd32,
                     12'd20, 2'b10);
      send_char(mk(1'b1, hgp_pkg::KIND_OTHER, 21'd66, 12'd10, 12'd3, 1'b1, 1'b1, 1'b0,
                   16'h0042, 1'b0));
      // rollback
      send_char(mk(1'b0, hgp_pkg::KIND_NEWLINE, 21'd10, 12'd0, 12'd0, 1'b0, 1'b1, 1'b0,
                   16'h0042, 1'b0));
      send_char(mk(1'b1, hgp_pkg::KIND_OTHER, 21'd67, 12'd0, 12'd3, 1'b0, 1'b1, 1'b1,
                   16'h0042, 1'b0));
      // keep
      send_char(mk(1'b0, hgp_pkg::KIND_NEWLINE, 21'd10, 12'd0, 12'd0, 1'b0, 1'b1, 1'b1,
                   16'h0042, 1'b0));
      send_char(mk(1'b1, hgp_pkg::KIND_OTHER, 21'd68, 12'd9, 12'd3, 1'b1, 1'b1, 1'b1,
                   16'h0042, 1'b0));
      // rollback and keep together: no break
      send_char(mk(1'b0, hgp_pkg::KIND_NEWLINE, 21'd10, 12'd0, 12'd0, 1'b0, 1'b1, 1'b1,
                   16'h0042, 1'b0));
      // keep asked at paragraph start: plain break
      send_char(mk(1'b0, hgp_pkg::KIND_NEWLINE, 21'd10, 12'd0, 12'd0, 1'b0, 1'b1, 1'b1,
                   16'h0042, 1'b0));
      send_char(mk(1'b0, hgp_pkg::KIND_NEWLINE, 21'd10, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0,
                   16'h0042, 1'b0));
      send_char(mk(1'b0, hgp_pkg::KIND_SPACE, 21'd32, 12'd0, 12'd0, 1'b0, 1'b1, 1'b0,
                   16'h0042, 1'b0));
      send_char(mk(1'b0, hgp_pkg::KIND_WIDE_SPACE, 21'd12288, 12'd0, 12'd0, 1'b0, 1'b1,
                   1'b0, 16'h0042, 1'b0));
      send_char(mk(1'b0, hgp_pkg::KIND_TAB, 21'd9, 12'd0, 12'd0, 1'b0, 1'b1, 1'b0,
                   16'h0042, 1'b0));
      send_char(mk(1'b1, hgp_pkg::KIND_OTHER, 21'd69, 12'd4, 12'd3, 1'b0, 1'b0, 1'b0,
                   16'h0042, 1'b1));

      // rotation swap with largest scale: advances wrap past 16 bits
      write_settings(32'h8000_7FF0, 16'hFFFF, 11'h3FF, 12'd4095, 12'd4095,
                     12'd4095, 12'd4095, 2'b11);
      send_char(mk(1'b1, hgp_pkg::KIND_OTHER, 21'd70, 12'd0, 12'd4095, 1'b0, 1'b1, 1'b0,
                   16'h7777, 1'b0));
      send_char(mk(1'b0, KIND_UNUSED_7, 21'd0, 12'd4095, 12'd1, 1'b0, 1'b1, 1'b0,
                   16'h7777, 1'b0));
      send_char(mk(1'b1, hgp_pkg::KIND_OTHER, 21'd71, 12'd1, 12'd4095, 1'b1, 1'b1, 1'b0,
                   16'h7777, 1'b0));
      send_char(mk(1'b0, hgp_pkg::KIND_NEWLINE, 21'd10, 12'd0, 12'd0, 1'b0, 1'b1, 1'b0,
                   16'h7777, 1'b1));
   endtask

   task automatic random_settings(input int epoch);
      logic [10:0] extra;
      logic [15:0] scale;
      logic [1:0]  mode;
      if (epoch == 1)
         write_settings(32'h0, 16'h0, 11'h400, 12'd0, 12'd0, 12'd0, 12'd0, 2'b10);
      else if (epoch == 2)
         write_settings(32'hFFFF_FFFF, 16'hFFFF, 11'h3FF, 12'd4095, 12'd4095,
                        12'd4095, 12'd4095, 2'b11);
      else begin
         scale = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(128, 512))
                                             : 16'($urandom);
         extra = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                             : 11'($urandom_range(0, 40) - 20);
         mode  = ($urandom_range(0, 3) == 0) ? 2'($urandom) : {1'b1, 1'($urandom)};
         write_settings($urandom, scale, extra, 12'($urandom_range(0, 64)),
                        12'($urandom_range(0, 128)), 12'($urandom_range(0, 256)),
                        12'($urandom_range(0, 80)), mode);
      end
   endtask

   // stimulus and verdict
   initial begin
      int epoch;
      int target;
      int drain;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_index     = hgp_pkg::CSR_START_POSITION;
      csr_wdata     = '0;
      idle_pct      = 0;
      stall_pct     = 0;
      chars_sent    = 0;
      settings_used = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_strings();

      // random strings: each pacing mix twice, new settings each time
      target = chars_sent;
      for (epoch = 0; epoch < EPOCHS; epoch++) begin
         random_settings(epoch);
         case (epoch % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 72; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 72; end
            default: begin idle_pct = 14; stall_pct = 14; end
         endcase
         target = target + EPOCH_CHARS;
         while (chars_sent < target)
            send_string();
      end

      // drain, then watch for stray placements
      req_valid <= 1'b0;
      drain = 0;
      while (placements_waiting != 0 && drain < 20000) begin
         @(negedge clock);
         drain++;
      end
      repeat (20) @(negedge clock);

      $display("tb: %0d characters under %0d register settings and four pacing mixes",
               chars_sent, settings_used);
      $display("tb: %0d placements compared, %0d of them rollback replacements",
               placements_checked, replacements_checked);
      if (mismatches == 0 && placements_waiting == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
